FILE: design/hfdm_pkg.sv
// ----------------------------------------------------------------------------
// hfdm_pkg: shared types and constants of the hysteresis frequency/duty meter
// Field widths, register indexes, reset values and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hfdm_pkg;

    localparam int CHANNELS      = 2;
    localparam int SAMPLE_BITS   = 12;
    localparam int TIME_BITS     = 32;
    localparam int WIN_BITS      = 16;
    localparam int FREQ_BITS     = 17;
    localparam int DUTY_BITS     = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // 1000 fits in 10 bits and 100 in 7 bits; these size the products.
    localparam int MS_BITS       = 10;
    localparam int MS_PER_S      = 1000;

    localparam logic [SAMPLE_BITS-1:0] LEVEL_HIGH_RESET = 12'd2304;
    localparam logic [SAMPLE_BITS-1:0] LEVEL_LOW_RESET  = 12'd1792;
    localparam logic [WIN_BITS-1:0]    WINDOW_RESET     = 16'd1000;
    localparam logic [FREQ_BITS-1:0]   FREQ_MAX         = 17'd99999;
    localparam logic [DUTY_BITS-1:0]   PERCENT          = 7'd100;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_HIGH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_LOW  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_MS  = 2'd2;

    // One division per channel for the frequency, then one per channel for the duty.
    localparam int OP_COUNT = 2 * CHANNELS;
    localparam int OP_BITS  = $clog2(OP_COUNT);
    localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [FREQ_BITS-1:0]   freq_t;
    typedef logic [DUTY_BITS-1:0]   duty_t;

    typedef struct packed {
        logic               step;
        logic               load;
        logic               div_step;
        logic               store;
        logic               publish;
        logic [OP_BITS-1:0] op;
    } hfdm_cmd_t;

    typedef struct packed {
        logic close;
    } hfdm_status_t;

endpackage

FILE: design/hfdm_div.sv
// ----------------------------------------------------------------------------
// hfdm_div: restoring divider, one quotient bit per step
// The dividend shifts out of the top of the quotient register while quotient
// bits shift in at the bottom; after DVD_W steps the register holds the
// quotient. A zero divisor is flagged for the caller.
// ----------------------------------------------------------------------------
module hfdm_div #(
    parameter int DVD_W = 42,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             divisor_zero
);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic             zero_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (step)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign quotient     = quo_reg;
    assign divisor_zero = zero_reg;

endmodule

FILE: design/hfdm_dpath.sv
// ----------------------------------------------------------------------------
// hfdm_dpath: datapath of the hysteresis frequency/duty meter
// Holds the threshold and window registers, the per-channel level decision
// and saturating counters, the window snapshot, the shared divider and the
// result and output registers.
// ----------------------------------------------------------------------------
module hfdm_dpath #(
    parameter int COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hfdm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [hfdm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  hfdm_pkg::sample_t                   samples [hfdm_pkg::CHANNELS],
    input  logic [hfdm_pkg::TIME_BITS-1:0]      now_ms,
    input  hfdm_pkg::hfdm_cmd_t                 cmd,
    output hfdm_pkg::hfdm_status_t              status,
    output hfdm_pkg::freq_t                     freq [hfdm_pkg::CHANNELS],
    output hfdm_pkg::duty_t                     duty [hfdm_pkg::CHANNELS]
);

    import hfdm_pkg::*;

    localparam int DVD_W = COUNT_BITS + MS_BITS;
    localparam int DVS_W = TIME_BITS;

    logic [SAMPLE_BITS-1:0] level_high_reg;
    logic [SAMPLE_BITS-1:0] level_low_reg;
    logic [WIN_BITS-1:0]    window_reg;

    logic                   level_bit_reg  [CHANNELS];
    logic [COUNT_BITS-1:0]  sample_cnt_reg [CHANNELS];
    logic [COUNT_BITS-1:0]  high_cnt_reg   [CHANNELS];
    logic [COUNT_BITS-1:0]  edge_cnt_reg   [CHANNELS];
    logic [TIME_BITS-1:0]   window_start_reg;

    logic [COUNT_BITS-1:0]  snap_sample_reg [CHANNELS];
    logic [COUNT_BITS-1:0]  snap_high_reg   [CHANNELS];
    logic [COUNT_BITS-1:0]  snap_edge_reg   [CHANNELS];
    logic [TIME_BITS-1:0]   snap_elapsed_reg;

    freq_t                  freq_res_reg [CHANNELS];
    duty_t                  duty_res_reg [CHANNELS];
    freq_t                  freq_out_reg [CHANNELS];
    duty_t                  duty_out_reg [CHANNELS];

    logic                   level_now  [CHANNELS];
    logic [COUNT_BITS-1:0]  sample_upd [CHANNELS];
    logic [COUNT_BITS-1:0]  high_upd   [CHANNELS];
    logic [COUNT_BITS-1:0]  edge_upd   [CHANNELS];

    logic [TIME_BITS-1:0]   elapsed;
    logic [WIN_BITS-1:0]    win_eff;

    logic                   is_duty;
    logic [OP_BITS-1:0]     ch_wide;
    logic [CH_BITS-1:0]     ch;
    logic [DVD_W-1:0]       dividend;
    logic [DVS_W-1:0]       divisor;
    logic [DVD_W-1:0]       quotient;
    logic                   divisor_zero;
    freq_t                  freq_val;
    duty_t                  duty_val;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_high_reg <= LEVEL_HIGH_RESET;
            level_low_reg  <= LEVEL_LOW_RESET;
            window_reg     <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEVEL_HIGH: level_high_reg <= cfg_data[SAMPLE_BITS-1:0];
                CFG_LEVEL_LOW:  level_low_reg  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_WINDOW_MS:  window_reg     <= cfg_data[WIN_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // A window length of zero behaves as one millisecond.
    always_comb
    begin
        elapsed      = now_ms - window_start_reg;
        win_eff      = (window_reg == '0) ? WIN_BITS'(1) : window_reg;
        status.close = (elapsed >= TIME_BITS'(win_eff));
    end

    // The high test wins when the thresholds cross.
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (samples[c] >= level_high_reg)
                level_now[c] = 1'b1;
            else if (samples[c] <= level_low_reg)
                level_now[c] = 1'b0;
            else
                level_now[c] = level_bit_reg[c];
            sample_upd[c] = sat_inc(sample_cnt_reg[c]);
            high_upd[c]   = level_now[c] ? sat_inc(high_cnt_reg[c]) : high_cnt_reg[c];
            edge_upd[c]   = (level_now[c] && !level_bit_reg[c]) ? sat_inc(edge_cnt_reg[c])
                                                                : edge_cnt_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                level_bit_reg[c]  <= 1'b0;
                sample_cnt_reg[c] <= '0;
                high_cnt_reg[c]   <= '0;
                edge_cnt_reg[c]   <= '0;
            end
            window_start_reg <= '0;
        end
        else if (cmd.step)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                level_bit_reg[c] <= level_now[c];
                if (status.close)
                begin
                    sample_cnt_reg[c] <= '0;
                    high_cnt_reg[c]   <= '0;
                    edge_cnt_reg[c]   <= '0;
                end
                else
                begin
                    sample_cnt_reg[c] <= sample_upd[c];
                    high_cnt_reg[c]   <= high_upd[c];
                    edge_cnt_reg[c]   <= edge_upd[c];
                end
            end
            if (status.close)
                window_start_reg <= now_ms;
        end
    end

    // The closing item's own sample is part of the window it closes.
    always_ff @(posedge clk)
    begin
        if (cmd.step && status.close)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                snap_sample_reg[c] <= sample_upd[c];
                snap_high_reg[c]   <= high_upd[c];
                snap_edge_reg[c]   <= edge_upd[c];
            end
            snap_elapsed_reg <= elapsed;
        end
    end

    always_comb
    begin
        is_duty = (cmd.op >= OP_BITS'(CHANNELS));
        ch_wide = is_duty ? cmd.op - OP_BITS'(CHANNELS) : cmd.op;
        ch      = ch_wide[CH_BITS-1:0];
        if (is_duty)
        begin
            dividend = DVD_W'(snap_high_reg[ch]) * DVD_W'(PERCENT)
                     + DVD_W'(snap_sample_reg[ch] >> 1);
            divisor  = DVS_W'(snap_sample_reg[ch]);
        end
        else
        begin
            dividend = DVD_W'(snap_edge_reg[ch]) * DVD_W'(MS_PER_S);
            divisor  = snap_elapsed_reg;
        end
        freq_val = (quotient > DVD_W'(FREQ_MAX)) ? FREQ_MAX : quotient[FREQ_BITS-1:0];
        if (divisor_zero)
            duty_val = '0;
        else if (quotient > DVD_W'(PERCENT))
            duty_val = PERCENT;
        else
            duty_val = quotient[DUTY_BITS-1:0];
    end

    hfdm_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk          (clk),
        .load         (cmd.load),
        .step         (cmd.div_step),
        .dividend     (dividend),
        .divisor      (divisor),
        .quotient     (quotient),
        .divisor_zero (divisor_zero)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (is_duty)
                duty_res_reg[ch] <= duty_val;
            else
                freq_res_reg[ch] <= freq_val;
        end
        if (cmd.publish)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                freq_out_reg[c] <= freq_res_reg[c];
                duty_out_reg[c] <= duty_res_reg[c];
            end
        end
    end

    assign freq = freq_out_reg;
    assign duty = duty_out_reg;

endmodule

FILE: design/hfdm_ctrl.sv
// ----------------------------------------------------------------------------
// hfdm_ctrl: controller of the hysteresis frequency/duty meter
// Accepts items, walks the divider through each frequency and duty division
// after a window closes, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module hfdm_ctrl #(
    parameter int COUNT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  hfdm_pkg::hfdm_status_t status,
    output hfdm_pkg::hfdm_cmd_t    cmd
);

    import hfdm_pkg::*;

    localparam int DVD_W     = COUNT_BITS + MS_BITS;
    localparam int ITER_BITS = $clog2(DVD_W + 1);
    localparam int OP_LAST   = OP_COUNT - 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [OP_BITS-1:0]   op_reg, op_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        iter_next    = iter_reg;
        cmd.step     = 1'b0;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.store    = 1'b0;
        cmd.publish  = 1'b0;
        cmd.op       = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.step = 1'b1;
                    if (status.close)
                    begin
                        op_next    = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                iter_next  = ITER_BITS'(DVD_W);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg - 1'b1;
                if (iter_reg == ITER_BITS'(1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.store = 1'b1;
                if (op_reg == OP_BITS'(OP_LAST))
                    state_next = ST_OUT;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                // The output register is free once its item has been taken.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/hysteresis_freq_duty_meter_top.sv
// ----------------------------------------------------------------------------
// hysteresis_freq_duty_meter_top: two-channel frequency and duty meter
// Judges each channel's samples with hysteresis and reports, once per time
// window, the rising-edge rate and the rounded high share per channel.
// ----------------------------------------------------------------------------
// An item that does not close the window is taken in the idle state, and the
// next item can follow in the next cycle. An item that closes the window starts
// four divisions on one shared restoring divider that produces one quotient
// bit per cycle; the input stalls after it until every division is stored and
// the result is published, longer if the previous result is still held in the
// output register. The output register lets a finished result wait while new
// items are taken.
module hysteresis_freq_duty_meter_top #(
    parameter int COUNT_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hfdm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [hfdm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  hfdm_pkg::sample_t                  sample_a,
    input  hfdm_pkg::sample_t                  sample_b,
    input  logic [hfdm_pkg::TIME_BITS-1:0]     now_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output hfdm_pkg::freq_t                    freq_a,
    output hfdm_pkg::freq_t                    freq_b,
    output hfdm_pkg::duty_t                    duty_a,
    output hfdm_pkg::duty_t                    duty_b
);

    import hfdm_pkg::*;

    hfdm_cmd_t    cmd;
    hfdm_status_t status;
    sample_t      samples [CHANNELS];
    freq_t        freq    [CHANNELS];
    duty_t        duty    [CHANNELS];

    assign samples[0] = sample_a;
    assign samples[1] = sample_b;

    hfdm_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hfdm_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .now_ms    (now_ms),
        .cmd       (cmd),
        .status    (status),
        .freq      (freq),
        .duty      (duty)
    );

    assign freq_a = freq[0];
    assign freq_b = freq[1];
    assign duty_a = duty[0];
    assign duty_b = duty[1];

endmodule
